### design/local_alignment_score_linear_gap_unit_assert.svh
// Assertion macros shared by the local alignment score unit.
// Defining NO_ASSERTIONS turns every macro into empty text.
`ifndef LOCAL_ALIGNMENT_SCORE_LINEAR_GAP_UNIT_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_LINEAR_GAP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks that a property holds at every clock edge outside reset.
`define LASG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that a condition holds in the cycle after a trigger, outside reset.
`define LASG_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define LASG_ASSERT(label, clk, rst, prop, msg)
`define LASG_ASSERT_NEXT(label, clk, rst, trig, cond, msg)
`endif
`endif

### design/lasg_pkg.sv
// Shared widths, codes, constants and link types of the local alignment score unit.
// No dependencies; every other file of the unit but the assertion header imports this package.
package lasg_pkg;

   localparam int unsigned QUERY_MAX_DEFAULT  = 64;
   localparam int unsigned COLUMN_MAX_DEFAULT = 16384;

   localparam int unsigned SYM_W      = 8;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned SCORE_W    = 8;
   localparam int unsigned GAP_W      = 7;
   localparam int unsigned QLEN_W     = 7;
   localparam int unsigned COL_W      = 14;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 7;

   // Signed working width for one cell update: score plus match bonus and sign.
   localparam int unsigned SCORE_EXT_W = SCORE_W + 2;

   localparam int unsigned COL_SAT = (2 ** COL_W) - 1;

   localparam logic signed [SCORE_EXT_W-1:0] MATCH_SCORE    = SCORE_EXT_W'(2);
   localparam logic signed [SCORE_EXT_W-1:0] MISMATCH_SCORE = SCORE_EXT_W'(-1);
   localparam logic signed [SCORE_EXT_W-1:0] SCORE_LIMIT    = SCORE_EXT_W'(255);

   localparam logic MODE_QUERY    = 1'b0;
   localparam logic MODE_DATABASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PENALTY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LENGTH = 1'b1;

   localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(1);
   localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(64);

   // One transaction as it moves down the row of cells, with the partial
   // results of its column gathered on the way.
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic [SYM_W-1:0]   symbol;
      logic [POS_W-1:0]   pos;
      logic               last;
      logic [SCORE_W-1:0] up;
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] colmax;
      logic [SCORE_W-1:0] bottom;
   } lasg_link_type;

   typedef struct packed {
      logic             advance;
      logic [GAP_W-1:0] gap_penalty;
   } lasg_cell_ctrl_type;

endpackage

### design/lasg_req_if.sv
// Request channel of the local alignment score unit: query loads and database symbols.
// Depends on lasg_pkg for the field widths.
interface lasg_req_if import lasg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             mode;
   logic [SYM_W-1:0] symbol;
   logic [POS_W-1:0] query_position;
   logic             last;

   modport source (output valid, mode, symbol, query_position, last, input ready);
   modport sink (input valid, mode, symbol, query_position, last, output ready);
endinterface

### design/lasg_rsp_if.sv
// Response channel of the local alignment score unit: one result per database column.
// Depends on lasg_pkg for the field widths.
interface lasg_rsp_if import lasg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] column_max;
   logic [SCORE_W-1:0] bottom_score;
   logic [SCORE_W-1:0] best_score;
   logic [COL_W-1:0]   column_index;
   logic               end_of_sequence;

   modport source (output valid, column_max, bottom_score, best_score, column_index,
                   end_of_sequence, input ready);
   modport sink (input valid, column_max, bottom_score, best_score, column_index,
                 end_of_sequence, output ready);
endinterface

### design/lasg_cell.sv
// One cell of the systolic row: holds one query symbol and one score of the column.
// Depends on lasg_pkg for the link and control types.
module lasg_cell import lasg_pkg::*; #(
   parameter int unsigned CELL_INDEX = 0,
   parameter int unsigned LEN_W      = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  lasg_cell_ctrl_type ctrl,
   input  logic [LEN_W-1:0]   active_len,
   input  lasg_link_type      link_i,
   output lasg_link_type      link_o
);

   localparam logic [LEN_W-1:0] CELL_ROW     = LEN_W'(CELL_INDEX);
   localparam bit               ADDRESSABLE  = CELL_INDEX < (2 ** POS_W);
   localparam logic [POS_W-1:0] CELL_POS     = POS_W'(CELL_INDEX);

   logic [SYM_W-1:0]   query_ff;
   logic [SCORE_W-1:0] score_ff;
   lasg_link_type      link_ff;
   lasg_link_type      link_in;

   logic                          cell_active;
   logic                          col_item;
   logic                          query_wr;
   logic signed [SCORE_EXT_W-1:0] sim;
   logic signed [SCORE_EXT_W-1:0] gap_s;
   logic signed [SCORE_EXT_W-1:0] diag_plus;
   logic signed [SCORE_EXT_W-1:0] up_gap;
   logic signed [SCORE_EXT_W-1:0] left_gap;
   logic signed [SCORE_EXT_W-1:0] best;
   logic [SCORE_W-1:0]            cell_score;

   assign cell_active = CELL_ROW < active_len;
   assign col_item    = link_i.valid && (link_i.mode == MODE_DATABASE);
   assign query_wr    = link_i.valid && (link_i.mode == MODE_QUERY) && ADDRESSABLE &&
                        (link_i.pos == CELL_POS);

   // The score stored here is still the previous column's value, so it serves as
   // the left neighbor now and as the diagonal for the cell below.
   always_comb begin
      sim       = (query_ff == link_i.symbol) ? MATCH_SCORE : MISMATCH_SCORE;
      gap_s     = $signed({3'b000, ctrl.gap_penalty});
      diag_plus = $signed({2'b00, link_i.diag}) + sim;
      up_gap    = $signed({2'b00, link_i.up}) - gap_s;
      left_gap  = $signed({2'b00, score_ff}) - gap_s;
      best      = diag_plus;
      if (up_gap > best) begin
         best = up_gap;
      end
      if (left_gap > best) begin
         best = left_gap;
      end
      if (best < 0) begin
         best = '0;
      end
      if (best > SCORE_LIMIT) begin
         best = SCORE_LIMIT;
      end
      cell_score = best[SCORE_W-1:0];
   end

   always_comb begin
      link_in      = link_i;
      link_in.diag = score_ff;
      if (cell_active && col_item) begin
         link_in.up     = cell_score;
         link_in.bottom = cell_score;
         link_in.colmax = (cell_score > link_i.colmax) ? cell_score : link_i.colmax;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= '0;
         score_ff <= '0;
      end else if (ctrl.advance) begin
         link_ff <= link_in;
         if (col_item) begin
            if (link_i.last) begin
               score_ff <= '0;
            end else if (cell_active) begin
               score_ff <= cell_score;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && query_wr) begin
         query_ff <= link_i.symbol;
      end
   end

   assign link_o = link_ff;

endmodule

### design/lasg_result.sv
// Result stage: running best score, column counter and the response register.
// Depends on lasg_pkg, lasg_rsp_if and the assertion macro header.
`include "local_alignment_score_linear_gap_unit_assert.svh"
module lasg_result import lasg_pkg::*; #(
   parameter int unsigned COLUMN_MAX = COLUMN_MAX_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  lasg_link_type link_i,
   output logic          advance,
   lasg_rsp_if.source    rsp_bus
);

   localparam int unsigned COL_LIMIT =
      ((COLUMN_MAX - 1) < COL_SAT) ? (COLUMN_MAX - 1) : COL_SAT;
   localparam logic [COL_W-1:0] COL_LIMIT_V = COL_W'(COL_LIMIT);

   logic               rsp_valid_ff;
   logic [SCORE_W-1:0] colmax_ff;
   logic [SCORE_W-1:0] bottom_ff;
   logic [SCORE_W-1:0] best_out_ff;
   logic [COL_W-1:0]   index_ff;
   logic               eos_ff;
   logic [SCORE_W-1:0] best_ff;
   logic [COL_W-1:0]   count_ff;

   logic               load_db;
   logic [SCORE_W-1:0] best_in;
   logic [COL_W-1:0]   count_in;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign load_db = advance && link_i.valid && (link_i.mode == MODE_DATABASE);
   assign best_in = (link_i.colmax > best_ff) ? link_i.colmax : best_ff;
   assign count_in = (count_ff < COL_LIMIT_V) ? count_ff + COL_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         best_ff      <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         rsp_valid_ff <= link_i.valid && (link_i.mode == MODE_DATABASE);
         if (load_db) begin
            best_ff  <= link_i.last ? '0 : best_in;
            count_ff <= link_i.last ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_db) begin
         colmax_ff   <= link_i.colmax;
         bottom_ff   <= link_i.bottom;
         best_out_ff <= best_in;
         index_ff    <= count_ff;
         eos_ff      <= link_i.last;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.column_max      = colmax_ff;
   assign rsp_bus.bottom_score    = bottom_ff;
   assign rsp_bus.best_score      = best_out_ff;
   assign rsp_bus.column_index    = index_ff;
   assign rsp_bus.end_of_sequence = eos_ff;

   `LASG_ASSERT(a_best_covers_column, clock, reset, rsp_bus.valid |-> (rsp_bus.best_score >= rsp_bus.column_max), "best score below column maximum")
   `LASG_ASSERT(a_bottom_in_column, clock, reset, rsp_bus.valid |-> (rsp_bus.bottom_score <= rsp_bus.column_max), "bottom score above column maximum")
   `LASG_ASSERT(a_counter_bound, clock, reset, count_ff <= COL_LIMIT_V, "column counter beyond its limit")
   `LASG_ASSERT_NEXT(a_last_clears, clock, reset, load_db && link_i.last, (count_ff == '0) && (best_ff == '0), "sequence state not cleared after last column")

endmodule

### design/local_alignment_score_linear_gap_unit.sv
// Smith-Waterman local alignment score unit, linear gap, as a systolic row of QUERY_MAX cells.
// Each database symbol passes through the register of every cell and then the result register.
// Throughput: one transaction per cycle; the row of cells and the result register all
// stall together while a response waits, so the rate is set by the response side alone.
// Reset clears the scores, best score, column counter, pipeline and registers to defaults;
// query symbols hold no reset value and must be loaded before use.
module local_alignment_score_linear_gap_unit import lasg_pkg::*; #(
   parameter int unsigned QUERY_MAX  = QUERY_MAX_DEFAULT,
   parameter int unsigned COLUMN_MAX = COLUMN_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   lasg_req_if.sink              req_bus,
   lasg_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned LEN_W = $clog2(QUERY_MAX + 1);

   logic [GAP_W-1:0]   gap_ff;
   logic [QLEN_W-1:0]  qlen_ff;
   logic [LEN_W-1:0]   active_len;
   logic               advance;
   lasg_cell_ctrl_type cell_ctrl;
   lasg_link_type      chain_link [QUERY_MAX+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= GAP_RESET;
         qlen_ff <= QLEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_PENALTY:  gap_ff  <= csr_wdata[GAP_W-1:0];
            CSR_QUERY_LENGTH: qlen_ff <= csr_wdata[QLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // A length of zero runs as one row, and any length above the row count as the full row.
   always_comb begin
      if (qlen_ff == '0) begin
         active_len = LEN_W'(1);
      end else if (32'(qlen_ff) > QUERY_MAX) begin
         active_len = LEN_W'(QUERY_MAX);
      end else begin
         active_len = LEN_W'(qlen_ff);
      end
   end

   assign cell_ctrl.advance     = advance;
   assign cell_ctrl.gap_penalty = gap_ff;
   assign req_bus.ready         = advance && !reset;

   // Row zero of the matrix is all zeros, so the first cell sees zero above and diagonal.
   always_comb begin
      chain_link[0]        = '0;
      chain_link[0].valid  = req_bus.valid;
      chain_link[0].mode   = req_bus.mode;
      chain_link[0].symbol = req_bus.symbol;
      chain_link[0].pos    = req_bus.query_position;
      chain_link[0].last   = req_bus.last;
   end

   for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
      lasg_cell #(
         .CELL_INDEX (g),
         .LEN_W      (LEN_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .active_len (active_len),
         .link_i     (chain_link[g]),
         .link_o     (chain_link[g+1])
      );
   end

   lasg_result #(
      .COLUMN_MAX (COLUMN_MAX)
   ) u_result (
      .clock   (clock),
      .reset   (reset),
      .link_i  (chain_link[QUERY_MAX]),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

endmodule
